>>> rtl/occ_pkg.sv
// ----------------------------------------------------------------------------
// occ_pkg
// Types and constants shared by the overlap combination counter.
// ----------------------------------------------------------------------------
package occ_pkg;

    localparam int unsigned VAL_W   = 30;
    localparam int unsigned COUNT_W = 13;
    localparam int unsigned KEY_W   = 32;

    localparam logic [VAL_W-1:0]   PRIME_MOD = 30'd998244353;
    localparam logic [VAL_W-1:0]   PRIME_EXP = 30'd998244351;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd8191;

    localparam logic [63:0] MU_FULL    = 64'h1000_0000_0000_0000 / 64'd998244353;
    localparam logic [30:0] BARRETT_MU = MU_FULL[30:0];

    typedef struct packed {
        logic             valid;
        logic [VAL_W-1:0] a;
        logic [VAL_W-1:0] b;
    } mm_req_t;

    typedef enum logic [3:0] {
        ST_FACT_WR,
        ST_FACT_WAIT,
        ST_EXP_SQ,
        ST_EXP_SQ_WAIT,
        ST_EXP_MUL,
        ST_EXP_MUL_WAIT,
        ST_EXP_STEP,
        ST_INV_WR,
        ST_INV_WAIT,
        ST_IDLE,
        ST_EV_RD,
        ST_EV_MUL1,
        ST_EV_WAIT1,
        ST_EV_WAIT2,
        ST_EV_FIN
    } state_t;

endpackage

>>> rtl/occ_mulmod.sv
// ----------------------------------------------------------------------------
// occ_mulmod
// Five-stage pipelined multiply modulo the prime, Barrett reduction.
// ----------------------------------------------------------------------------
module occ_mulmod (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  occ_pkg::mm_req_t           req,
    output logic                       res_valid,
    output logic [occ_pkg::VAL_W-1:0]  res
);
    import occ_pkg::*;

    logic [4:0]         vld_reg;
    logic [59:0]        prod_reg;
    logic [61:0]        q1_reg;
    logic [31:0]        x2_reg;
    logic [31:0]        x3_reg;
    logic [31:0]        qp_reg;
    logic [31:0]        r_reg;
    logic [VAL_W-1:0]   res_reg;
    logic [59:0]        qp_full;
    logic [31:0]        p32;

    assign p32     = 32'(PRIME_MOD);
    assign qp_full = 60'(q1_reg[60:31]) * 60'(PRIME_MOD);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[3:0], req.valid};
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= 60'(req.a) * 60'(req.b);
        q1_reg   <= 62'(prod_reg[59:29]) * 62'(BARRETT_MU);
        x2_reg   <= prod_reg[31:0];
        x3_reg   <= x2_reg;
        qp_reg   <= qp_full[31:0];
        r_reg    <= x3_reg - qp_reg;
        if (r_reg >= {p32[30:0], 1'b0}) begin
            res_reg <= VAL_W'(r_reg - {p32[30:0], 1'b0});
        end else if (r_reg >= p32) begin
            res_reg <= VAL_W'(r_reg - p32);
        end else begin
            res_reg <= VAL_W'(r_reg);
        end
    end

    assign res_valid = vld_reg[4];
    assign res       = res_reg;

endmodule

>>> rtl/overlap_combination_counter.sv
// ----------------------------------------------------------------------------
// overlap_combination_counter
// Sweeps sorted interval events and sums C(count-1, size-1) mod 998244353.
// ----------------------------------------------------------------------------
// An event that adds no term goes straight to its result; one that does reads
// the tables, then makes two passes through the 5-stage modular multiplier.
// Events are taken one at a time: the next is accepted only once the result of
// the last is in the output register, which may have to wait for m_tready.
// Reset: synchronous; the factorial and inverse factorial memories are then
// filled, with s_tready low throughout.
module overlap_combination_counter #(
    parameter int unsigned TABLE_DEPTH = 4096
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [occ_pkg::COUNT_W-1:0]   cfg_wr_data,  // group_size
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,      // position
    input  logic                          s_tuser,      // func
    input  logic                          s_tlast,      // end_of_set
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // running_total, overlap_count, order_error, table_overflow
    output logic [47:0]                   m_tdata
);
    import occ_pkg::*;

    localparam int unsigned AW = $clog2(TABLE_DEPTH + 1);

    logic [VAL_W-1:0] fact_mem [TABLE_DEPTH+1];
    logic [VAL_W-1:0] invf_mem [TABLE_DEPTH+1];
    logic [VAL_W-1:0] fact_rd_reg;
    logic [VAL_W-1:0] invf_rd_reg;
    logic             fact_we, invf_we, fact_re, invf_re;
    logic [AW-1:0]    waddr, fact_raddr, invf_raddr;
    logic [VAL_W-1:0] wdata;

    state_t             state_reg, state_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [VAL_W-1:0]   acc_reg, acc_next;
    logic [VAL_W-1:0]   base_reg, base_next;
    logic [4:0]         bit_reg, bit_next;
    logic [COUNT_W-1:0] group_size_reg;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [VAL_W-1:0]   total_reg, total_next;
    logic [KEY_W-1:0]   prev_key_reg, prev_key_next;
    logic [KEY_W-1:0]   ev_key_reg, ev_key_next;
    logic [COUNT_W-1:0] ev_cnt_reg, ev_cnt_next;
    logic               ev_oe_reg, ev_oe_next;
    logic               ev_ovf_reg, ev_ovf_next;
    logic               ev_last_reg, ev_last_next;
    logic [AW-1:0]      ev_n_reg, ev_n_next;
    logic [AW-1:0]      ev_r_reg, ev_r_next;
    logic [AW-1:0]      ev_nr_reg, ev_nr_next;
    logic [VAL_W:0]     sum_reg, sum_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [47:0]        m_tdata_reg, m_tdata_next;

    mm_req_t            mm_req;
    logic               mm_done;
    logic [VAL_W-1:0]   mm_res;

    logic [KEY_W-1:0]   in_key;
    logic [COUNT_W-1:0] in_cnt, in_n, in_r;
    logic               in_due, in_ovf;
    logic               out_free;
    logic [VAL_W-1:0]   total_fin;

    occ_mulmod u_mulmod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (mm_req),
        .res_valid (mm_done),
        .res       (mm_res)
    );

    always_ff @(posedge aclk) begin
        if (fact_we) begin
            fact_mem[waddr] <= wdata;
        end
        if (invf_we) begin
            invf_mem[waddr] <= wdata;
        end
        if (fact_re) begin
            fact_rd_reg <= fact_mem[fact_raddr];
        end
        if (invf_re) begin
            invf_rd_reg <= invf_mem[invf_raddr];
        end
    end

    always_comb begin
        if (s_tuser) begin
            in_key = {{1'b0, s_tdata[29:0]} + 31'd1, 1'b0};
            in_cnt = (count_reg != '0) ? count_reg - 1'b1 : count_reg;
        end else begin
            in_key = {1'b0, s_tdata[29:0], 1'b1};
            in_cnt = (count_reg != COUNT_MAX) ? count_reg + 1'b1 : count_reg;
        end
        in_due = !s_tuser && (group_size_reg != '0) && (in_cnt >= group_size_reg);
        in_ovf = in_due && (32'(in_cnt) > 32'(TABLE_DEPTH));
        in_n   = in_cnt - 1'b1;
        in_r   = group_size_reg - 1'b1;
    end

    assign out_free  = !m_tvalid_reg || m_tready;
    assign total_fin = (sum_reg >= {1'b0, PRIME_MOD}) ? VAL_W'(sum_reg - {1'b0, PRIME_MOD})
                                                      : VAL_W'(sum_reg);

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        acc_next      = acc_reg;
        base_next     = base_reg;
        bit_next      = bit_reg;
        count_next    = count_reg;
        total_next    = total_reg;
        prev_key_next = prev_key_reg;
        ev_key_next   = ev_key_reg;
        ev_cnt_next   = ev_cnt_reg;
        ev_oe_next    = ev_oe_reg;
        ev_ovf_next   = ev_ovf_reg;
        ev_last_next  = ev_last_reg;
        ev_n_next     = ev_n_reg;
        ev_r_next     = ev_r_reg;
        ev_nr_next    = ev_nr_reg;
        sum_next      = sum_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        mm_req        = '0;
        fact_we       = 1'b0;
        invf_we       = 1'b0;
        fact_re       = 1'b0;
        invf_re       = 1'b0;
        waddr         = idx_reg;
        wdata         = acc_reg;
        fact_raddr    = ev_n_reg;
        invf_raddr    = ev_r_reg;
        s_tready      = 1'b0;

        case (state_reg)
            ST_FACT_WR: begin
                fact_we = 1'b1;
                if (idx_reg == AW'(TABLE_DEPTH)) begin
                    base_next  = acc_reg;
                    acc_next   = VAL_W'(1);
                    bit_next   = 5'(VAL_W - 1);
                    state_next = ST_EXP_SQ;
                end else begin
                    mm_req     = '{valid: 1'b1, a: acc_reg, b: VAL_W'(idx_reg) + 1'b1};
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_FACT_WAIT;
                end
            end
            ST_FACT_WAIT: begin
                if (mm_done) begin
                    acc_next   = mm_res;
                    state_next = ST_FACT_WR;
                end
            end
            ST_EXP_SQ: begin
                mm_req     = '{valid: 1'b1, a: acc_reg, b: acc_reg};
                state_next = ST_EXP_SQ_WAIT;
            end
            ST_EXP_SQ_WAIT: begin
                if (mm_done) begin
                    acc_next   = mm_res;
                    state_next = PRIME_EXP[bit_reg] ? ST_EXP_MUL : ST_EXP_STEP;
                end
            end
            ST_EXP_MUL: begin
                mm_req     = '{valid: 1'b1, a: acc_reg, b: base_reg};
                state_next = ST_EXP_MUL_WAIT;
            end
            ST_EXP_MUL_WAIT: begin
                if (mm_done) begin
                    acc_next   = mm_res;
                    state_next = ST_EXP_STEP;
                end
            end
            ST_EXP_STEP: begin
                if (bit_reg == '0) begin
                    state_next = ST_INV_WR;
                end else begin
                    bit_next   = bit_reg - 1'b1;
                    state_next = ST_EXP_SQ;
                end
            end
            ST_INV_WR: begin
                invf_we = 1'b1;
                if (idx_reg == '0) begin
                    state_next = ST_IDLE;
                end else begin
                    mm_req     = '{valid: 1'b1, a: acc_reg, b: VAL_W'(idx_reg)};
                    idx_next   = idx_reg - 1'b1;
                    state_next = ST_INV_WAIT;
                end
            end
            ST_INV_WAIT: begin
                if (mm_done) begin
                    acc_next   = mm_res;
                    state_next = ST_INV_WR;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    ev_key_next  = in_key;
                    ev_oe_next   = in_key < prev_key_reg;
                    ev_cnt_next  = in_cnt;
                    ev_ovf_next  = in_ovf;
                    ev_last_next = s_tlast;
                    ev_n_next    = AW'(32'(in_n));
                    ev_r_next    = AW'(32'(in_r));
                    ev_nr_next   = AW'(32'(in_n - in_r));
                    sum_next     = {1'b0, total_reg};
                    state_next   = (in_due && !in_ovf) ? ST_EV_RD : ST_EV_FIN;
                end
            end
            ST_EV_RD: begin
                fact_re    = 1'b1;
                invf_re    = 1'b1;
                state_next = ST_EV_MUL1;
            end
            ST_EV_MUL1: begin
                mm_req     = '{valid: 1'b1, a: fact_rd_reg, b: invf_rd_reg};
                invf_re    = 1'b1;
                invf_raddr = ev_nr_reg;
                state_next = ST_EV_WAIT1;
            end
            ST_EV_WAIT1: begin
                if (mm_done) begin
                    mm_req     = '{valid: 1'b1, a: mm_res, b: invf_rd_reg};
                    state_next = ST_EV_WAIT2;
                end
            end
            ST_EV_WAIT2: begin
                if (mm_done) begin
                    sum_next   = {1'b0, total_reg} + {1'b0, mm_res};
                    state_next = ST_EV_FIN;
                end
            end
            ST_EV_FIN: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b000, ev_ovf_reg, ev_oe_reg, ev_cnt_reg, total_fin};
                    count_next    = ev_last_reg ? '0 : ev_cnt_reg;
                    total_next    = ev_last_reg ? '0 : total_fin;
                    prev_key_next = ev_last_reg ? '0 : ev_key_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_FACT_WR;
            idx_reg        <= '0;
            acc_reg        <= VAL_W'(1);
            group_size_reg <= COUNT_W'(1);
            count_reg      <= '0;
            total_reg      <= '0;
            prev_key_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            acc_reg        <= acc_next;
            if (cfg_wr_en) begin
                group_size_reg <= cfg_wr_data;
            end
            count_reg      <= count_next;
            total_reg      <= total_next;
            prev_key_reg   <= prev_key_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        base_reg    <= base_next;
        bit_reg     <= bit_next;
        ev_key_reg  <= ev_key_next;
        ev_cnt_reg  <= ev_cnt_next;
        ev_oe_reg   <= ev_oe_next;
        ev_ovf_reg  <= ev_ovf_next;
        ev_last_reg <= ev_last_next;
        ev_n_reg    <= ev_n_next;
        ev_r_reg    <= ev_r_next;
        ev_nr_reg   <= ev_nr_next;
        sum_reg     <= sum_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> test/tb_overlap_combination_counter.sv
// ----------------------------------------------------------------------------
// tb_overlap_combination_counter
// Drives sorted and unsorted interval events through the overlap combination
// counter under random source and sink stalls, predicts every result with an
// independent binomial-sum calculation and compares each transfer in order.
// ----------------------------------------------------------------------------
module tb_overlap_combination_counter;
    timeunit 1ns;
    timeprecision 1ps;
    import occ_pkg::*;

    localparam int unsigned DEPTH     = 4096;
    localparam logic [31:0] P         = 32'd998244353;
    localparam logic        EV_BEGIN  = 1'b0;
    localparam logic        EV_END    = 1'b1;
    localparam int          CYCLE_CAP = 3000000;

    typedef struct packed {
        logic        overflow;
        logic        order_err;
        logic [12:0] count;
        logic [29:0] total;
    } occ_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [12:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    logic [31:0] fact_tab [0:DEPTH];
    logic [31:0] ifact_tab [0:DEPTH];
    logic [31:0] inv_tab [0:DEPTH];

    logic [12:0] size_reg;
    logic [12:0] open_cnt;
    logic [31:0] sum_acc;
    logic [31:0] last_key;
    occ_result_t pending_results [$];
    int          errors = 0;
    int          cycles = 0;
    bit          calm = 1'b0;

    overlap_combination_counter #(.TABLE_DEPTH(DEPTH)) dut (.*);

    always #6 aclk = ~aclk;

    function automatic logic [31:0] mulp(logic [31:0] a, logic [31:0] b);
        logic [63:0] x;
        x = 64'(a) * 64'(b);
        return 32'(x % 64'(P));
    endfunction

    function automatic void build_tables();
        inv_tab[0] = 1; inv_tab[1] = 1;
        ifact_tab[0] = 1; ifact_tab[1] = 1;
        fact_tab[0] = 1; fact_tab[1] = 1;
        for (int i = 2; i <= DEPTH; i++) begin
            inv_tab[i] = mulp(inv_tab[P % i], P - P / i);
            ifact_tab[i] = mulp(inv_tab[i], ifact_tab[i-1]);
            fact_tab[i] = mulp(fact_tab[i-1], 32'(i));
        end
    endfunction

    function automatic void predict_sweep(logic fn, logic [29:0] pos, logic eos);
        logic [31:0] key;
        logic [31:0] term;
        occ_result_t r;
        key = (fn == EV_END) ? (32'(pos) + 1) * 2 : 32'(pos) * 2 + 1;
        r.order_err = key < last_key;
        r.overflow = 1'b0;
        last_key = key;
        if (fn == EV_END) begin
            if (open_cnt > 0) open_cnt--;
        end else begin
            if (open_cnt < 13'h1FFF) open_cnt++;
            if (size_reg != 0 && open_cnt >= size_reg) begin
                if (open_cnt > DEPTH) begin
                    r.overflow = 1'b1;
                end else begin
                    term = mulp(mulp(fact_tab[open_cnt-1], ifact_tab[size_reg-1]),
                                ifact_tab[open_cnt - size_reg]);
                    sum_acc = sum_acc + term;
                    if (sum_acc >= P) sum_acc -= P;
                end
            end
        end
        r.total = sum_acc[29:0];
        r.count = open_cnt;
        pending_results.insert(pending_results.size(), r);
        if (eos) begin
            open_cnt = 0; sum_acc = 0; last_key = 0;
        end
    endfunction

    task automatic send_event(logic fn, logic [29:0] pos, logic eos);
        while (!calm && $urandom_range(99) < 28) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, pos};
        s_tuser <= fn;
        s_tlast <= eos;
        do @(posedge aclk); while (!s_tready);
        predict_sweep(fn, pos, eos);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic set_group_size(logic [12:0] v);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        size_reg = v;
    endtask

    task automatic close_set();
        send_event(EV_END, 30'h3FFFFFFE, 1'b1);
    endtask

    task automatic test_extremes();
        send_event(EV_BEGIN, 30'd0, 1'b0);
        send_event(EV_END, 30'h3FFFFFFF, 1'b0);
        send_event(EV_END, 30'd5, 1'b0);
        send_event(EV_BEGIN, 30'd3, 1'b0);
        send_event(EV_END, 30'd2, 1'b1);
        send_event(EV_END, 30'd1, 1'b0);
        send_event(EV_BEGIN, 30'd1, 1'b0);
        send_event(EV_BEGIN, 30'h2AAAAAAA, 1'b0);
        send_event(EV_BEGIN, 30'h15555555, 1'b1);
    endtask

    task automatic test_sizes();
        set_group_size(13'd0);
        for (int i = 0; i < 5; i++) send_event(EV_BEGIN, 30'(i), 1'b0);
        close_set();
        set_group_size(13'd3);
        for (int i = 0; i < 8; i++) send_event(EV_BEGIN, 30'(i), 1'b0);
        close_set();
    endtask

    task automatic test_deep_overlap();
        calm = 1'b1;
        set_group_size(13'd40);
        for (int i = 0; i < 120; i++) send_event(EV_BEGIN, 30'd7, i == 119);
        set_group_size(13'h1FFF);
        for (int i = 0; i < 20; i++) send_event(EV_BEGIN, 30'd7, i == 19);
        calm = 1'b0;
    endtask

    task automatic test_random_sweeps(int n_items);
        int sent;
        logic [29:0] pos;
        logic fn;
        sent = 0;
        while (sent < n_items) begin
            set_group_size(13'($urandom_range(0, 9) == 0 ? $urandom_range(0, 8191)
                                                         : $urandom_range(1, 6)));
            calm = ($urandom_range(0, 5) == 0);
            pos = 30'($urandom_range(0, 1000));
            for (int k = $urandom_range(5, 60); k > 0; k--) begin
                fn = ($urandom_range(0, 99) < 55) ? EV_BEGIN : EV_END;
                if ($urandom_range(0, 19) == 0)
                    pos = 30'($urandom);
                else
                    pos = pos + 30'($urandom_range(0, 3));
                send_event(fn, pos, k == 1);
                sent++;
            end
            if ($urandom_range(0, 7) == 0) drain();
        end
        calm = 1'b0;
    endtask

    always @(posedge aclk) begin
        occ_result_t got;
        occ_result_t want;
        if (aresetn) begin
            m_tready <= calm || ($urandom_range(99) >= 28);
            if (m_tvalid && m_tready) begin
                got = occ_result_t'(m_tdata[44:0]);
                if (pending_results.size() == 0) begin
                    $error("unexpected result transfer %h", m_tdata);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.total !== want.total) begin
                        $error("running_total exp %0d got %0d", want.total, got.total);
                        errors++;
                    end
                    if (got.count !== want.count) begin
                        $error("overlap_count exp %0d got %0d", want.count, got.count);
                        errors++;
                    end
                    if (got.order_err !== want.order_err) begin
                        $error("order_error exp %0b got %0b", want.order_err,
                               got.order_err);
                        errors++;
                    end
                    if (got.overflow !== want.overflow) begin
                        $error("table_overflow exp %0b got %0b", want.overflow,
                               got.overflow);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        build_tables();
        size_reg = 13'd1; open_cnt = 0; sum_acc = 0; last_key = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_extremes();
        test_sizes();
        test_deep_overlap();
        test_random_sweeps(1686);
        set_group_size(13'd1);
        drain();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
